// ----- design/cell_voltage_temp_monitor_unit_defines.svh -----
// Assertion macros for the cell voltage / temperature monitor checker.
// No dependencies; included by the checker file only.
`ifndef CELL_VOLTAGE_TEMP_MONITOR_UNIT_DEFINES_SVH
`define CELL_VOLTAGE_TEMP_MONITOR_UNIT_DEFINES_SVH

// Same-cycle implication, reset-qualified
`define CVTM_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, reset-qualified
`define CVTM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/cvtm_pkg.sv -----
// Shared types and constants for the cell voltage / temperature monitor.
// No dependencies; used by every module of the block.
package cvtm_pkg;

  localparam int ADC_BITS    = 10;
  localparam int SAMPLE_W    = 10;
  localparam int FS_W        = ADC_BITS + 1;
  localparam int FULL_SCALE  = 1 << ADC_BITS;
  localparam int ADC_MAX     = FULL_SCALE - 1;

  localparam int REF_W       = 13;
  localparam int BETA_W      = 14;
  localparam int NTC_W       = 7;
  localparam int CFG_DATA_W  = 14;
  localparam int CFG_IDX_W   = 2;
  localparam int VAL_W       = 16;
  localparam int MUX_W       = 4;

  localparam logic [MUX_W-1:0] MUX_BANDGAP    = 4'd12;
  localparam logic [MUX_W-1:0] MUX_THERMISTOR = 4'd2;
  localparam int KELVIN_OFFS = 27315;
  localparam int LN2_Q16     = 45426;
  localparam logic [VAL_W-1:0] VAL_SAT = 16'hFFFF;

  localparam logic CH_VOLT = 1'b0;
  localparam logic CH_TEMP = 1'b1;

  // Queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REF  = 2'd0,
    CFG_BETA = 2'd1,
    CFG_NTC  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [REF_W-1:0]  ref_mv;
    logic [BETA_W-1:0] beta;
    logic [NTC_W-1:0]  ntc;
  } cfg_t;

  typedef struct packed {
    logic                ch;
    logic [SAMPLE_W-1:0] sample;
  } item_t;

  typedef struct packed {
    logic  push;
    item_t item;
  } q_push_t;

  typedef struct packed {
    logic  valid;
    logic  full;
    item_t item;
  } q_stat_t;

  typedef struct packed {
    logic             ch;
    logic [VAL_W-1:0] value;
    logic [VAL_W-1:0] vnow;
    logic [VAL_W-1:0] tnow;
    logic [MUX_W-1:0] mux;
    logic             fault;
  } result_t;

endpackage

// ----- design/cvtm_front.sv -----
// Front end: accepts ADC transactions and tags each with its channel.
// Depends on cvtm_pkg.
module cvtm_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          sample_valid_i,
  output logic                          sample_ready_o,
  input  logic [cvtm_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                          q_full_i,
  output cvtm_pkg::q_push_t             push_o
);

  logic chan_q, chan_d;
  logic take;

  assign sample_ready_o = !q_full_i;
  assign take           = sample_valid_i && !q_full_i;

  // channels alternate, voltage first
  assign chan_d = take ? !chan_q : chan_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_q <= cvtm_pkg::CH_VOLT;
    end else begin
      chan_q <= chan_d;
    end
  end

  assign push_o.push        = take;
  assign push_o.item.ch     = chan_q;
  assign push_o.item.sample = sample_i;

endmodule

// ----- design/cvtm_queue.sv -----
// Short queue between the front end and the compute back end.
// Depends on cvtm_pkg.
module cvtm_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cvtm_pkg::q_push_t push_i,
  input  logic              pop_i,
  output cvtm_pkg::q_stat_t stat_o
);

  cvtm_pkg::item_t mem_q [cvtm_pkg::Q_DEPTH];
  logic [cvtm_pkg::Q_PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [cvtm_pkg::Q_CNT_W-1:0] cnt_q, cnt_d;
  logic do_push, do_pop;

  assign do_push = push_i.push && (cnt_q != cvtm_pkg::Q_CNT_W'(cvtm_pkg::Q_DEPTH));
  assign do_pop  = pop_i && (cnt_q != '0);

  // pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == cvtm_pkg::Q_PTR_W'(cvtm_pkg::Q_DEPTH - 1)) ? '0
                 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == cvtm_pkg::Q_PTR_W'(cvtm_pkg::Q_DEPTH - 1)) ? '0
                 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // payload storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.item;
    end
  end

  assign stat_o.valid = (cnt_q != '0);
  assign stat_o.full  = (cnt_q == cvtm_pkg::Q_CNT_W'(cvtm_pkg::Q_DEPTH));
  assign stat_o.item  = mem_q[rd_ptr_q];

endmodule

// ----- design/cvtm_back.sv -----
// Back end: sequenced log2 unit, multipliers and shared restoring divider,
// stored channel values and the registered result. Depends on cvtm_pkg.
module cvtm_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cvtm_pkg::cfg_t        cfg_i,
  input  cvtm_pkg::q_stat_t     q_i,
  output logic                  pop_o,
  output logic                  result_valid_o,
  input  logic                  result_ready_i,
  output cvtm_pkg::result_t     result_o
);

  localparam int LOG_W  = 20;
  localparam int L_W    = 21;
  localparam int X_W    = 31;
  localparam int T0C_W  = 16;
  localparam int P1_W   = 38;
  localparam int P2_W   = 56;
  localparam int BH_W   = 21;
  localparam int TB_W   = 30;
  localparam int NM_W   = 37;
  localparam int DEN_W  = 40;
  localparam int DVD_W  = 53;
  localparam int QUO_W  = 17;
  localparam int REM_W  = DEN_W + QUO_W;
  localparam int LSTEPS = 16;
  localparam int LCNT_W = $clog2(LSTEPS);
  localparam int DCNT_W = $clog2(QUO_W);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_LOG  = 8'b0000_0010,
    S_MUL1 = 8'b0000_0100,
    S_MUL2 = 8'b0000_1000,
    S_MUL3 = 8'b0001_0000,
    S_DCHK = 8'b0010_0000,
    S_DIV  = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  logic                          ch_q, ch_d;
  logic [cvtm_pkg::SAMPLE_W-1:0] s_q, s_d;
  logic                          fault_q, fault_d;
  logic [cvtm_pkg::VAL_W-1:0]    val_q, val_d;
  logic [X_W-1:0]                x_q, x_d;
  logic [LOG_W-1:0]              y_q, y_d, la_q, la_d;
  logic                          half_q, half_d;
  logic [LCNT_W-1:0]             lcnt_q, lcnt_d;
  logic signed [L_W-1:0]         l_q, l_d;
  logic [T0C_W-1:0]              t0c_q, t0c_d;
  logic signed [P1_W-1:0]        p1_q, p1_d;
  logic signed [P2_W-1:0]        p2_q, p2_d;
  logic [BH_W-1:0]               bh_q, bh_d;
  logic [TB_W-1:0]               tb_q, tb_d;
  logic [NM_W-1:0]               nm_q, nm_d;
  logic [DEN_W-1:0]              den_q, den_d;
  logic [DVD_W-1:0]              dvd_q, dvd_d;
  logic [REM_W-1:0]              rem_q, rem_d, dv_q, dv_d;
  logic [QUO_W-1:0]              quo_q, quo_d;
  logic [DCNT_W-1:0]             dcnt_q, dcnt_d;

  logic                          rv_q, rv_d;
  cvtm_pkg::result_t             res_q, res_d;
  logic [cvtm_pkg::VAL_W-1:0]    sv_q, sv_d, st_q, st_d;

  // log2 datapath signals
  logic [2*X_W-1:0]              sq;
  logic [X_W:0]                  sq_hi;
  logic [X_W-1:0]                x_next;
  logic [LOG_W-1:0]              y_next;
  logic [cvtm_pkg::SAMPLE_W-1:0] comp_s;
  logic [X_W-1:0]                norm_x_s, norm_x_c;
  logic [LOG_W-1:0]              norm_y_s, norm_y_c;

  logic signed [P2_W-1:0]        dfull;
  logic [DEN_W-1:0]              dsh;
  logic                          rem_ge;
  logic [QUO_W-1:0]              quo_next;
  logic signed [QUO_W+1:0]       cent;
  logic [cvtm_pkg::VAL_W-1:0]    fin_val;

  // leading-one normalise into Q30 mantissa and integer log part
  function automatic logic [X_W+LOG_W-1:0] norm(input logic [cvtm_pkg::SAMPLE_W-1:0] n);
    logic [3:0] msb;
    logic [X_W-1:0] x;
    logic [LOG_W-1:0] y;
    msb = '0;
    for (int i = 1; i < cvtm_pkg::SAMPLE_W; i++) begin
      if (n[i]) begin
        msb = 4'(i);
      end
    end
    x = X_W'(n) << (5'd30 - 5'(msb));
    y = LOG_W'(msb) << 16;
    return {x, y};
  endfunction

  assign comp_s = cvtm_pkg::SAMPLE_W'(cvtm_pkg::FS_W'(cvtm_pkg::FULL_SCALE) - {1'b0, s_q});
  assign {norm_x_s, norm_y_s} = norm(q_i.item.sample);
  assign {norm_x_c, norm_y_c} = norm(comp_s);

  // one squaring step of the log2 fraction
  assign sq     = x_q * x_q;
  assign sq_hi  = sq[2*X_W-1:X_W-1];
  assign x_next = sq_hi[X_W] ? sq_hi[X_W:1] : sq_hi[X_W-1:0];
  assign y_next = sq_hi[X_W] ? (y_q | (LOG_W'(1) << (4'(LSTEPS - 1) - lcnt_q))) : y_q;

  // denominator of the beta form
  assign dfull = $signed({3'b0, bh_q, 32'b0}) + p2_q;
  assign dsh   = dfull[P2_W-1:16];

  // restoring divider step
  assign rem_ge   = (rem_q >= dv_q);
  assign quo_next = {quo_q[QUO_W-2:0], rem_ge};
  assign cent     = $signed({2'b0, quo_next}) - (QUO_W+2)'(cvtm_pkg::KELVIN_OFFS);

  // final saturation per channel
  always_comb begin
    if (ch_q == cvtm_pkg::CH_VOLT) begin
      fin_val = (quo_next[QUO_W-1]) ? cvtm_pkg::VAL_SAT : quo_next[cvtm_pkg::VAL_W-1:0];
    end else if (cent[QUO_W+1]) begin
      fin_val = '0;
    end else if (cent[QUO_W:cvtm_pkg::VAL_W] != '0) begin
      fin_val = cvtm_pkg::VAL_SAT;
    end else begin
      fin_val = cent[cvtm_pkg::VAL_W-1:0];
    end
  end

  assign pop_o = (state_q == S_IDLE) && q_i.valid;

  // sequencer
  always_comb begin
    state_d = state_q;
    ch_d = ch_q;       s_d = s_q;       fault_d = fault_q; val_d = val_q;
    x_d = x_q;         y_d = y_q;       la_d = la_q;       half_d = half_q;
    lcnt_d = lcnt_q;   l_d = l_q;       t0c_d = t0c_q;
    p1_d = p1_q;       p2_d = p2_q;     bh_d = bh_q;       tb_d = tb_q;
    nm_d = nm_q;       den_d = den_q;   dvd_d = dvd_q;
    rem_d = rem_q;     dv_d = dv_q;     quo_d = quo_q;     dcnt_d = dcnt_q;
    rv_d = rv_q;       res_d = res_q;   sv_d = sv_q;       st_d = st_q;

    if (rv_q && result_ready_i) begin
      rv_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (q_i.valid) begin
          ch_d    = q_i.item.ch;
          s_d     = q_i.item.sample;
          fault_d = 1'b0;
          t0c_d   = T0C_W'(cfg_i.ntc) * T0C_W'(100) + T0C_W'(cvtm_pkg::KELVIN_OFFS);
          if (q_i.item.sample == '0) begin
            fault_d = 1'b1;
            val_d   = cvtm_pkg::VAL_SAT;
            state_d = S_DONE;
          end else if (q_i.item.ch == cvtm_pkg::CH_VOLT) begin
            dvd_d   = DVD_W'(cfg_i.ref_mv) * DVD_W'(cvtm_pkg::ADC_MAX);
            den_d   = DEN_W'(q_i.item.sample);
            state_d = S_DCHK;
          end else if ({1'b0, q_i.item.sample} >= cvtm_pkg::FS_W'(cvtm_pkg::FULL_SCALE)) begin
            fault_d = 1'b1;
            val_d   = '0;
            state_d = S_DONE;
          end else begin
            x_d     = norm_x_s;
            y_d     = norm_y_s;
            half_d  = 1'b0;
            lcnt_d  = '0;
            state_d = S_LOG;
          end
        end
      end
      S_LOG: begin
        x_d    = x_next;
        y_d    = y_next;
        lcnt_d = lcnt_q + 1'b1;
        if (lcnt_q == LCNT_W'(LSTEPS - 1)) begin
          if (!half_q) begin
            la_d   = y_next;
            x_d    = norm_x_c;
            y_d    = norm_y_c;
            half_d = 1'b1;
            lcnt_d = '0;
          end else begin
            l_d     = $signed({1'b0, la_q}) - $signed({1'b0, y_next});
            state_d = S_MUL1;
          end
        end
      end
      S_MUL1: begin
        p1_d    = $signed({1'b0, t0c_q}) * l_q;
        tb_d    = TB_W'(t0c_q) * TB_W'(cfg_i.beta);
        bh_d    = BH_W'(cfg_i.beta) * BH_W'(100);
        state_d = S_MUL2;
      end
      S_MUL2: begin
        p2_d    = p1_q * $signed({1'b0, 16'(cvtm_pkg::LN2_Q16)});
        nm_d    = NM_W'(tb_q) * NM_W'(100);
        state_d = S_MUL3;
      end
      S_MUL3: begin
        if (dfull[P2_W-1] || dfull == '0 || dsh == '0) begin
          fault_d = 1'b1;
          val_d   = cvtm_pkg::VAL_SAT;
          state_d = S_DONE;
        end else begin
          den_d   = dsh;
          dvd_d   = {nm_q, 16'b0};
          state_d = S_DCHK;
        end
      end
      S_DCHK: begin
        // quotient at or above 2^17 saturates either channel
        if (REM_W'(dvd_q) >= {den_q, QUO_W'(0)}) begin
          val_d   = cvtm_pkg::VAL_SAT;
          state_d = S_DONE;
        end else begin
          rem_d   = REM_W'(dvd_q);
          dv_d    = REM_W'({den_q, 16'b0});
          quo_d   = '0;
          dcnt_d  = '0;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        rem_d  = rem_ge ? rem_q - dv_q : rem_q;
        dv_d   = dv_q >> 1;
        quo_d  = quo_next;
        dcnt_d = dcnt_q + 1'b1;
        if (dcnt_q == DCNT_W'(QUO_W - 1)) begin
          val_d   = fin_val;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!rv_q || result_ready_i) begin
          rv_d        = 1'b1;
          res_d.ch    = ch_q;
          res_d.value = val_q;
          res_d.fault = fault_q;
          res_d.vnow  = (ch_q == cvtm_pkg::CH_VOLT) ? val_q : sv_q;
          res_d.tnow  = (ch_q == cvtm_pkg::CH_TEMP) ? val_q : st_q;
          res_d.mux   = (ch_q == cvtm_pkg::CH_VOLT) ? cvtm_pkg::MUX_THERMISTOR
                                                    : cvtm_pkg::MUX_BANDGAP;
          if (ch_q == cvtm_pkg::CH_VOLT) begin
            sv_d = val_q;
          end else begin
            st_d = val_q;
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control and stored values
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rv_q    <= 1'b0;
      sv_q    <= '0;
      st_q    <= '0;
    end else begin
      state_q <= state_d;
      rv_q    <= rv_d;
      sv_q    <= sv_d;
      st_q    <= st_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    ch_q <= ch_d;     s_q <= s_d;       fault_q <= fault_d; val_q <= val_d;
    x_q <= x_d;       y_q <= y_d;       la_q <= la_d;       half_q <= half_d;
    lcnt_q <= lcnt_d; l_q <= l_d;       t0c_q <= t0c_d;
    p1_q <= p1_d;     p2_q <= p2_d;     bh_q <= bh_d;       tb_q <= tb_d;
    nm_q <= nm_d;     den_q <= den_d;   dvd_q <= dvd_d;
    rem_q <= rem_d;   dv_q <= dv_d;     quo_q <= quo_d;     dcnt_q <= dcnt_d;
    res_q <= res_d;
  end

  assign result_valid_o = rv_q;
  assign result_o       = res_q;

endmodule

// ----- design/cell_voltage_temp_monitor_unit.sv -----
// Top level of the cell voltage / temperature monitor.
// Depends on cvtm_pkg, cvtm_front, cvtm_queue and cvtm_back.
//
//  channel   | handshake                    | payload
//  ----------+------------------------------+-----------------------------------
//  sample    | sample_valid_i/sample_ready_o| sample_i
//  result    | result_valid_o/result_ready_i| channel_o, computed_value_o, ...
//  config    | cfg_we_i (no wait)           | cfg_idx_i, cfg_data_i
//
// The temperature path runs two 16-step log2 squarings on one multiplier, and both
// channels share a 17-step restoring divider. A zero sample goes straight to the
// result.
// Reset is asynchronous and active low; no clearing pass is needed.
// A two-entry queue keeps accepting samples, until it is full, while the back end
// works or the result waits in its output register.
module cell_voltage_temp_monitor_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            sample_valid_i,
  output logic                            sample_ready_o,
  input  logic [cvtm_pkg::SAMPLE_W-1:0]   sample_i,
  output logic                            result_valid_o,
  input  logic                            result_ready_i,
  output logic                            channel_o,
  output logic [cvtm_pkg::VAL_W-1:0]      computed_value_o,
  output logic [cvtm_pkg::VAL_W-1:0]      voltage_now_o,
  output logic [cvtm_pkg::VAL_W-1:0]      temp_now_o,
  output logic [cvtm_pkg::MUX_W-1:0]      next_mux_o,
  output logic                            div_fault_o,
  input  logic                            cfg_we_i,
  input  logic [cvtm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [cvtm_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  cvtm_pkg::cfg_t    cfg_q, cfg_d;
  cvtm_pkg::q_push_t push;
  cvtm_pkg::q_stat_t qstat;
  cvtm_pkg::result_t res;
  logic              pop;

  // configuration register writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        cvtm_pkg::CFG_REF:  cfg_d.ref_mv = cfg_data_i[cvtm_pkg::REF_W-1:0];
        cvtm_pkg::CFG_BETA: cfg_d.beta   = cfg_data_i[cvtm_pkg::BETA_W-1:0];
        cvtm_pkg::CFG_NTC:  cfg_d.ntc    = cfg_data_i[cvtm_pkg::NTC_W-1:0];
        default:            cfg_d        = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ref_mv <= cvtm_pkg::REF_W'(1100);
      cfg_q.beta   <= cvtm_pkg::BETA_W'(3950);
      cfg_q.ntc    <= cvtm_pkg::NTC_W'(25);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  cvtm_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .sample_valid_i (sample_valid_i),
    .sample_ready_o (sample_ready_o),
    .sample_i       (sample_i),
    .q_full_i       (qstat.full),
    .push_o         (push)
  );

  cvtm_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .stat_o (qstat)
  );

  cvtm_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .q_i            (qstat),
    .pop_o          (pop),
    .result_valid_o (result_valid_o),
    .result_ready_i (result_ready_i),
    .result_o       (res)
  );

  assign channel_o        = res.ch;
  assign computed_value_o = res.value;
  assign voltage_now_o    = res.vnow;
  assign temp_now_o       = res.tnow;
  assign next_mux_o       = res.mux;
  assign div_fault_o      = res.fault;

endmodule

// ----- design/cvtm_checker.sv -----
// Port-level checks for the cell voltage / temperature monitor, bound to the top.
// Depends on cvtm_pkg and cell_voltage_temp_monitor_unit_defines.svh.
`include "cell_voltage_temp_monitor_unit_defines.svh"

module cvtm_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       result_valid_o,
  input logic                       result_ready_i,
  input logic                       channel_o,
  input logic [cvtm_pkg::VAL_W-1:0] computed_value_o,
  input logic [cvtm_pkg::VAL_W-1:0] voltage_now_o,
  input logic [cvtm_pkg::VAL_W-1:0] temp_now_o,
  input logic [cvtm_pkg::MUX_W-1:0] next_mux_o,
  input logic                       div_fault_o
);

  // the mux code always points at the other channel
  `CVTM_ASSERT_NOW(a_mux_follows, clk_i, rst_ni, result_valid_o, next_mux_o == (channel_o ? cvtm_pkg::MUX_BANDGAP : cvtm_pkg::MUX_THERMISTOR), "next_mux does not follow channel")

  // the reported stored value matches the fresh value of its channel
  `CVTM_ASSERT_NOW(a_store_match, clk_i, rst_ni, result_valid_o, (channel_o ? temp_now_o : voltage_now_o) == computed_value_o, "stored value differs from computed value")

  // a fault leaves a saturated value, or zero on the temperature channel
  `CVTM_ASSERT_NOW(a_fault_sat, clk_i, rst_ni, result_valid_o && div_fault_o, computed_value_o == cvtm_pkg::VAL_SAT || (channel_o && computed_value_o == '0), "fault without saturated value")

  // a stalled result holds
  `CVTM_ASSERT_NEXT(a_hold, clk_i, rst_ni, result_valid_o && !result_ready_i, result_valid_o && $stable(computed_value_o) && $stable(channel_o), "stalled result changed")

endmodule

bind cell_voltage_temp_monitor_unit cvtm_checker u_cvtm_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .result_valid_o   (result_valid_o),
  .result_ready_i   (result_ready_i),
  .channel_o        (channel_o),
  .computed_value_o (computed_value_o),
  .voltage_now_o    (voltage_now_o),
  .temp_now_o       (temp_now_o),
  .next_mux_o       (next_mux_o),
  .div_fault_o      (div_fault_o)
);

// ----- tb/tb_cell_voltage_temp_monitor_unit.sv -----
// Self-checking testbench for cell_voltage_temp_monitor_unit.
// Depends on cvtm_pkg and the block's RTL; predicts every result with a built-in
// fixed-point model, checks each result transaction in order, and stresses the handshakes.
`timescale 1ns / 100ps

module tb_cell_voltage_temp_monitor_unit;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned SETTLE_CYC  = 80;
  // index with no register behind it
  localparam logic [cvtm_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  // Monitor predictor and in-order store of expected readings
  class monitor_scoreboard;
    logic [cvtm_pkg::REF_W-1:0]  ref_mv;
    logic [cvtm_pkg::BETA_W-1:0] beta;
    logic [cvtm_pkg::NTC_W-1:0]  ntc;
    logic                        chan;
    logic [cvtm_pkg::VAL_W-1:0]  volt_store;
    logic [cvtm_pkg::VAL_W-1:0]  temp_store;
    cvtm_pkg::result_t           readings_due[$];
    int unsigned                 errors;

    function void reset_state();
      ref_mv = 13'd1100;
      beta = 14'd3950;
      ntc = 7'd25;
      chan = cvtm_pkg::CH_VOLT;
      volt_store = '0;
      temp_store = '0;
      readings_due.delete();
      errors = 0;
    endfunction

    function void write_reg(logic [cvtm_pkg::CFG_IDX_W-1:0] idx,
                            logic [cvtm_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        cvtm_pkg::CFG_REF:  ref_mv = data[cvtm_pkg::REF_W-1:0];
        cvtm_pkg::CFG_BETA: beta = data[cvtm_pkg::BETA_W-1:0];
        cvtm_pkg::CFG_NTC:  ntc = data[cvtm_pkg::NTC_W-1:0];
        default: ;
      endcase
    endfunction

    // log2 in Q16, fraction bits by repeated squaring of a Q30 mantissa
    function automatic longint log2_q16(int unsigned n);
      int msb;
      longint unsigned x;
      longint y;
      msb = 0;
      while (msb < 15 && (n >> (msb + 1)) != 0) msb++;
      y = longint'(msb) * 65536;
      x = longint'(n) << (30 - msb);
      for (int i = 1; i <= 16; i++) begin
        x = (x * x) >> 30;
        if (x >= 64'h8000_0000) begin
          x = x >> 1;
          y += longint'(1) << (16 - i);
        end
      end
      return y;
    endfunction

    function automatic logic [cvtm_pkg::VAL_W-1:0] supply_mv(int unsigned s,
                                                             output logic flt);
      longint unsigned q;
      flt = 1'b0;
      if (s == 0) begin
        flt = 1'b1;
        return cvtm_pkg::VAL_SAT;
      end
      q = (longint'(ref_mv) * cvtm_pkg::ADC_MAX) / s;
      return (q > 65535) ? cvtm_pkg::VAL_SAT : q[cvtm_pkg::VAL_W-1:0];
    endfunction

    function automatic logic [cvtm_pkg::VAL_W-1:0] temp_centi(int unsigned s,
                                                              output logic flt);
      longint l, t0c, b, d, num, tc, c;
      flt = 1'b0;
      if (s == 0) begin
        flt = 1'b1;
        return cvtm_pkg::VAL_SAT;
      end
      if (s >= cvtm_pkg::FULL_SCALE) begin
        flt = 1'b1;
        return '0;
      end
      l = log2_q16(s) - log2_q16(cvtm_pkg::FULL_SCALE - s);
      t0c = longint'(ntc) * 100 + cvtm_pkg::KELVIN_OFFS;
      b = longint'(beta);
      d = b * 100 * (longint'(1) << 32) + t0c * l * cvtm_pkg::LN2_Q16;
      if (d <= 0) begin
        flt = 1'b1;
        return cvtm_pkg::VAL_SAT;
      end
      d = d >>> 16;
      if (d == 0) begin
        flt = 1'b1;
        return cvtm_pkg::VAL_SAT;
      end
      num = t0c * b * 100 * 65536;
      tc = num / d;
      c = tc - cvtm_pkg::KELVIN_OFFS;
      if (c < 0) return '0;
      if (c > 65535) return cvtm_pkg::VAL_SAT;
      return c[cvtm_pkg::VAL_W-1:0];
    endfunction

    function void note_sample(logic [cvtm_pkg::SAMPLE_W-1:0] s);
      cvtm_pkg::result_t r;
      logic flt;
      r.ch = chan;
      if (chan == cvtm_pkg::CH_VOLT) begin
        r.value = supply_mv(s, flt);
        volt_store = r.value;
      end else begin
        r.value = temp_centi(s, flt);
        temp_store = r.value;
      end
      chan = ~chan;
      r.vnow = volt_store;
      r.tnow = temp_store;
      r.mux = (chan == cvtm_pkg::CH_TEMP) ? cvtm_pkg::MUX_THERMISTOR : cvtm_pkg::MUX_BANDGAP;
      r.fault = flt;
      readings_due.push_back(r);
    endfunction

    function void check_reading(cvtm_pkg::result_t act);
      cvtm_pkg::result_t e;
      if (readings_due.size() == 0) begin
        $display("%0t: unexpected result transaction %p", $time, act);
        errors++;
        return;
      end
      e = readings_due.pop_front();
      if (act.ch !== e.ch) begin
        $display("%0t: channel exp %0d got %0d", $time, e.ch, act.ch); errors++;
      end
      if (act.value !== e.value) begin
        $display("%0t: computed_value exp %0d got %0d", $time, e.value, act.value); errors++;
      end
      if (act.vnow !== e.vnow) begin
        $display("%0t: voltage_now exp %0d got %0d", $time, e.vnow, act.vnow); errors++;
      end
      if (act.tnow !== e.tnow) begin
        $display("%0t: temp_now exp %0d got %0d", $time, e.tnow, act.tnow); errors++;
      end
      if (act.mux !== e.mux) begin
        $display("%0t: next_mux exp %0d got %0d", $time, e.mux, act.mux); errors++;
      end
      if (act.fault !== e.fault) begin
        $display("%0t: div_fault exp %0d got %0d", $time, e.fault, act.fault); errors++;
      end
    endfunction
  endclass

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            sample_valid_i = 1'b0;
  logic                            sample_ready_o;
  logic [cvtm_pkg::SAMPLE_W-1:0]   sample_i = '0;
  logic                            result_valid_o;
  logic                            result_ready_i = 1'b0;
  logic                            channel_o;
  logic [cvtm_pkg::VAL_W-1:0]      computed_value_o;
  logic [cvtm_pkg::VAL_W-1:0]      voltage_now_o;
  logic [cvtm_pkg::VAL_W-1:0]      temp_now_o;
  logic [cvtm_pkg::MUX_W-1:0]      next_mux_o;
  logic                            div_fault_o;
  logic                            cfg_we_i = 1'b0;
  logic [cvtm_pkg::CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [cvtm_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  monitor_scoreboard sb;
  int unsigned cycles = 0;
  int unsigned src_idle_pct = 0;
  int unsigned sink_idle_pct = 0;
  int unsigned sink_hold_req = 0;
  int unsigned sink_hold = 0;

  cell_voltage_temp_monitor_unit dut (.*);

  always #5 clk_i = ~clk_i;

  // Cycle limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result side: random stalls plus one long hold-off on request
  always @(negedge clk_i) begin
    if (sink_hold_req != 0) begin
      sink_hold = sink_hold_req;
      sink_hold_req = 0;
    end
    if (sink_hold != 0) begin
      sink_hold--;
      result_ready_i <= 1'b0;
    end else begin
      result_ready_i <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Result check
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o && result_ready_i)
      sb.check_reading({channel_o, computed_value_o, voltage_now_o, temp_now_o,
                        next_mux_o, div_fault_o});
  end

  // One sample transaction; called and returns at a falling edge
  task automatic send_sample(logic [cvtm_pkg::SAMPLE_W-1:0] s);
    while ($urandom_range(99) < src_idle_pct) begin
      sample_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    sample_valid_i <= 1'b1;
    sample_i <= s;
    do @(posedge clk_i); while (!sample_ready_o);
    sb.note_sample(s);
    @(negedge clk_i);
  endtask

  // Let the block drain and settle before a register write
  task automatic drain();
    sample_valid_i <= 1'b0;
    while (sb.readings_due.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYC) @(negedge clk_i);
  endtask

  // one write cycle, then cfg_we_i drops before the next write
  task automatic write_reg(logic [cvtm_pkg::CFG_IDX_W-1:0] idx,
                           logic [cvtm_pkg::CFG_DATA_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic logic [cvtm_pkg::SAMPLE_W-1:0] pick_sample();
    if ($urandom_range(9) == 0) begin
      case ($urandom_range(4))
        0: return '0;
        1: return 10'd1;
        2: return 10'd1022;
        3: return 10'd512;
        default: return 10'd1023;
      endcase
    end
    return cvtm_pkg::SAMPLE_W'($urandom_range(1023));
  endfunction

  initial begin
    logic [cvtm_pkg::SAMPLE_W-1:0] directed[$];
    int unsigned ref_set[7]  = '{1100, 5000, 0, 8191, 3300, 1, 2500};
    int unsigned beta_set[7] = '{3950, 10000, 1000, 16383, 0, 1, 3435};
    int unsigned ntc_set[7]  = '{25, 100, 0, 127, 50, 1, 0};

    sb = new();
    sb.reset_state();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: zero samples on both channels, full scale, tiny, mid-scale,
    // cold clamp and saturating voltage
    directed = '{10'd0, 10'd0, 10'd1023, 10'd1023, 10'd1, 10'd1, 10'd512, 10'd512,
                 10'd1, 10'd1023, 10'd1023, 10'd1, 10'd341, 10'd682, 10'd2, 10'd1000};
    foreach (directed[i]) send_sample(directed[i]);

    // Random phases, each under its own register setting
    for (int p = 0; p < 7; p++) begin
      drain();
      write_reg(cvtm_pkg::CFG_REF, cvtm_pkg::CFG_DATA_W'(ref_set[p]));
      write_reg(cvtm_pkg::CFG_BETA, cvtm_pkg::CFG_DATA_W'(beta_set[p]));
      write_reg(cvtm_pkg::CFG_NTC, cvtm_pkg::CFG_DATA_W'(ntc_set[p]));
      if (p == 5) write_reg(CFG_SPARE, cvtm_pkg::CFG_DATA_W'($urandom_range(16383)));
      src_idle_pct = (p < 2) ? 9 : (p < 4) ? 52 : 0;
      sink_idle_pct = (p < 2) ? 52 : (p < 4) ? 9 : 0;
      if (p == 4) sink_hold_req = 400;
      for (int n = 0; n < 148; n++) send_sample(pick_sample());
    end

    drain();
    if (sb.errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+design
design/cvtm_pkg.sv
design/cvtm_front.sv
design/cvtm_queue.sv
design/cvtm_back.sv
design/cell_voltage_temp_monitor_unit.sv
design/cvtm_checker.sv
tb/tb_cell_voltage_temp_monitor_unit.sv
